FILE: design/tpqm_pkg.sv
`timescale 1ns / 1ps

package tpqm_pkg;

  localparam int AXES        = 3;
  localparam int MOTOR_COUNT = 4;
  localparam int AX_W        = 2;
  localparam int MOT_W       = 2;

  // Derivative divider widths: dividend up to 38 bits, divisor 20 bits
  localparam int DIV_W   = 38;
  localparam int DVSR_W  = 20;
  localparam int CNT_W   = 6;

  // Integrator scale: x / 500000 = ((x >> 5) * INT_RECIP) >> INT_RECIP_SH,
  // exact for x >> 5 below 2^31
  localparam logic [31:0]       INT_RECIP    = 32'd2251799814;
  localparam int                INT_RECIP_SH = 45;
  localparam logic [20:0]       DERIV_SCALE  = 21'd2000000;

  // Command codes
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_ARM    = 2'd1;
  localparam logic [1:0] CMD_DISARM = 2'd2;
  localparam logic [1:0] CMD_RSVD   = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_GAIN0   = 3'd0;
  localparam logic [2:0] REG_GAIN1   = 3'd1;
  localparam logic [2:0] REG_GAIN2   = 3'd2;
  localparam logic [2:0] REG_ENABLE  = 3'd3;
  localparam logic [2:0] REG_SIGNS   = 3'd4;
  localparam logic [2:0] REG_FLOOR   = 3'd5;
  localparam logic [2:0] REG_CEILING = 3'd6;
  localparam logic [2:0] REG_IDLE    = 3'd7;

  // Register reset values
  localparam logic [47:0] GAIN_RST    = 48'd1099528405248;
  localparam logic [2:0]  ENABLE_RST  = 3'd5;
  localparam logic [11:0] SIGNS_RST   = 12'd3101;
  localparam logic [15:0] FLOOR_RST   = 16'd1000;
  localparam logic [15:0] CEILING_RST = 16'd2000;
  localparam logic [15:0] IDLE_RST    = 16'd900;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [19:0]        dt_us;
    logic signed [15:0] measured_yaw;
    logic signed [15:0] measured_pitch;
    logic signed [15:0] measured_roll;
    logic signed [15:0] target_yaw;
    logic signed [15:0] target_pitch;
    logic signed [15:0] target_roll;
    logic signed [15:0] throttle_stick;
  } in_t;

  typedef struct packed {
    logic [15:0] motor_front_right;
    logic [15:0] motor_front_left;
    logic [15:0] motor_back_left;
    logic [15:0] motor_back_right;
  } out_t;

  // One regulator entry of the state memory
  typedef struct packed {
    logic signed [31:0] integ;
    logic signed [15:0] prev;
    logic signed [31:0] rout;
  } axis_st_t;

  localparam int ST_W = $bits(axis_st_t);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: design/three_axis_pid_quad_motor_mixer_unit.sv
`timescale 1ns / 1ps
// Channel | Direction | Beat content                         | Handshake
// in_     | input     | tpqm_pkg::in_t (cmd, dt, angles, thr) | in_valid / in_ready
// out_    | output    | tpqm_pkg::out_t (four PWM commands)   | out_valid / out_ready
// cfg_    | input     | register index and 48-bit data        | cfg_we, no wait
// A control tick reads and loads each axis; an enabled axis then scales and updates
// its integral, runs the 38-step derivative divider unless dt is zero, multiplies and
// sums. Mixer states then run per motor, then the output state. Arm and ignored beats
// stay in idle; an armed disarm goes to output. Regulator state sits in a 3-entry
// RAM with per-entry valid bits, so reset and disarm clear it at once.
// A finished beat waits in the output register; the next input is taken meanwhile,
// and a following result holds in the output state until that register drains.

module three_axis_pid_quad_motor_mixer_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tpqm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tpqm_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_idx,
  input  logic [47:0]    cfg_wdata
);
  import tpqm_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_RD     = 12'b000000000010,
    S_LOAD   = 12'b000000000100,
    S_ISCALE = 12'b000000001000,
    S_INTEG  = 12'b000000010000,
    S_DIV2   = 12'b000000100000,
    S_MUL    = 12'b000001000000,
    S_SUM    = 12'b000010000000,
    S_MIXA   = 12'b000100000000,
    S_MIXB   = 12'b001000000000,
    S_MIXC   = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [47:0] gains_r [AXES];
  logic [2:0]  en_r;
  logic [11:0] signs_r;
  logic [15:0] floor_r, ceil_r, idle_r;

  // Control and datapath registers
  in_t                   in_r;
  logic                  armed_r;
  logic [AXES-1:0]       vld_r;
  logic [AX_W-1:0]       ax_r;
  logic [MOT_W-1:0]      m_r;
  logic signed [31:0]    integ_r;
  logic signed [16:0]    e_r, d_r;
  logic signed [31:0]    rsh_r [AXES];
  logic [DVSR_W-1:0]     rem_r, dvsr_r;
  logic [DIV_W-1:0]      quo_r;
  logic [CNT_W-1:0]      cnt_r;
  logic signed [32:0]    p1_r;
  logic signed [47:0]    p2_r;
  logic signed [54:0]    p3_r;
  logic signed [51:0]    lvl_r;
  logic signed [50:0]    scl_r;
  logic [15:0]           mot_r [MOTOR_COUNT];
  out_t                  out_r;
  logic                  out_valid_r;

  // State memory
  axis_st_t              ram_q, ram_d;
  logic                  ram_we;

  tpqm_ram #(.W(ST_W), .D(AXES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ax_r),
    .wdata (ram_d),
    .raddr (ax_r),
    .rdata (ram_q)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXES; a++) gains_r[a] <= GAIN_RST;
      en_r    <= ENABLE_RST;
      signs_r <= SIGNS_RST;
      floor_r <= FLOOR_RST;
      ceil_r  <= CEILING_RST;
      idle_r  <= IDLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_GAIN0:   gains_r[0] <= cfg_wdata;
        REG_GAIN1:   gains_r[1] <= cfg_wdata;
        REG_GAIN2:   gains_r[2] <= cfg_wdata;
        REG_ENABLE:  en_r       <= cfg_wdata[2:0];
        REG_SIGNS:   signs_r    <= cfg_wdata[11:0];
        REG_FLOOR:   floor_r    <= cfg_wdata[15:0];
        REG_CEILING: ceil_r     <= cfg_wdata[15:0];
        REG_IDLE:    idle_r     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Select the current axis inputs and gains
  logic signed [15:0] meas_sel, targ_sel;
  logic [47:0]        gain_sel;
  always_comb begin
    case (ax_r)
      2'd0: begin
        meas_sel = in_r.measured_yaw;
        targ_sel = in_r.target_yaw;
        gain_sel = gains_r[0];
      end
      2'd1: begin
        meas_sel = in_r.measured_pitch;
        targ_sel = in_r.target_pitch;
        gain_sel = gains_r[1];
      end
      default: begin
        meas_sel = in_r.measured_roll;
        targ_sel = in_r.target_roll;
        gain_sel = gains_r[2];
      end
    endcase
  end

  // Error and measurement delta, with unwritten entries reading as zero
  axis_st_t           st_ld;
  logic signed [16:0] e_c, d_c;
  logic [16:0]        e_abs, d_abs;
  logic [36:0]        prod1;
  logic [37:0]        prod2;
  always_comb begin
    st_ld = vld_r[ax_r] ? ram_q : '0;
    e_c   = {targ_sel[15], targ_sel} - {meas_sel[15], meas_sel};
    d_c   = {meas_sel[15], meas_sel} - {st_ld.prev[15], st_ld.prev};
    e_abs = e_c[16] ? 17'(-e_c) : 17'(e_c);
    d_abs = d_r[16] ? 17'(-d_r) : 17'(d_r);
    prod1 = e_abs * in_r.dt_us;
    prod2 = d_abs * DERIV_SCALE;
  end

  // Restoring divider step, one quotient bit per cycle
  logic [DVSR_W:0]  div_sh, div_sub;
  logic             div_ge;
  always_comb begin
    div_sh  = {rem_r, quo_r[DIV_W-1]};
    div_ge  = div_sh >= {1'b0, dvsr_r};
    div_sub = div_sh - {1'b0, dvsr_r};
  end

  // Integrator scale by reciprocal multiply, then update
  logic [63:0]        iprod;
  logic signed [38:0] q1s;
  logic signed [39:0] isum;
  always_comb begin
    iprod = 64'(quo_r[36:5]) * 64'(INT_RECIP);
    q1s  = e_r[16] ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    isum = 40'(integ_r) + 40'(q1s);
  end

  // PID sum, floor shift and saturation
  logic signed [56:0] pid_sum;
  logic signed [31:0] rout_new;
  always_comb begin
    pid_sum = 57'($signed({p1_r, 1'b0})) + 57'(p2_r)
            + (d_r[16] ? 57'(p3_r) : -57'(p3_r));
    rout_new = sat32(64'(pid_sum >>> 8));
  end

  always_comb begin
    ram_we      = (state_r == S_SUM);
    ram_d.integ = integ_r;
    ram_d.prev  = meas_sel;
    ram_d.rout  = rout_new;
  end

  // Mixer: signed weight sum, level clamp, command scale and clamp
  logic [2:0]         msel;
  logic signed [34:0] wsum;
  logic [15:0]        thr;
  logic [32:0]        lvlc;
  logic signed [16:0] span;
  logic signed [19:0] cmd_c;
  logic [15:0]        cmd_clamp, idle_clamp;
  always_comb begin
    case (m_r)
      2'd0:    msel = signs_r[2:0];
      2'd1:    msel = signs_r[5:3];
      2'd2:    msel = signs_r[8:6];
      default: msel = signs_r[11:9];
    endcase
    wsum = 35'sd65536;
    for (int a = 0; a < AXES; a++) begin
      wsum = msel[a] ? wsum - 35'(rsh_r[a]) : wsum + 35'(rsh_r[a]);
    end
    thr = {~in_r.throttle_stick[15], in_r.throttle_stick[14:0]};
    if (lvl_r < 52'sd0) lvlc = '0;
    else if (lvl_r > 52'sd4294967296) lvlc = 33'h100000000;
    else lvlc = lvl_r[32:0];
    span  = $signed({1'b0, ceil_r}) - $signed({1'b0, floor_r});
    cmd_c = 20'($signed({1'b0, floor_r})) + 20'(scl_r >>> 32);
    if (cmd_c < $signed({4'b0, idle_r})) cmd_clamp = idle_r;
    else if (cmd_c > $signed({4'b0, ceil_r})) cmd_clamp = ceil_r;
    else cmd_clamp = cmd_c[15:0];
    idle_clamp = (idle_r > ceil_r) ? ceil_r : idle_r;
  end

  logic in_fire, out_load, last_ax;
  always_comb begin
    in_ready = (state_r == S_IDLE);
    in_fire  = in_valid && in_ready;
    out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);
    last_ax  = (ax_r == AX_W'(AXES - 1));
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.cmd == CMD_TICK && armed_r) state_nxt = S_RD;
          else if (in_data.cmd == CMD_DISARM && armed_r) state_nxt = S_OUT;
        end
      end
      S_RD:     state_nxt = S_LOAD;
      S_LOAD: begin
        if (en_r[ax_r]) state_nxt = S_ISCALE;
        else if (last_ax) state_nxt = S_MIXA;
        else state_nxt = S_RD;
      end
      S_ISCALE: state_nxt = S_INTEG;
      S_INTEG:  state_nxt = (in_r.dt_us == '0) ? S_MUL : S_DIV2;
      S_DIV2:   if (cnt_r == CNT_W'(1)) state_nxt = S_MUL;
      S_MUL:    state_nxt = S_SUM;
      S_SUM:    state_nxt = last_ax ? S_MIXA : S_RD;
      S_MIXA:   state_nxt = S_MIXB;
      S_MIXB:   state_nxt = S_MIXC;
      S_MIXC:   state_nxt = (m_r == MOT_W'(MOTOR_COUNT - 1)) ? S_OUT : S_MIXA;
      S_OUT:    if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      armed_r     <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire && in_data.cmd == CMD_ARM) armed_r <= 1'b1;
      if (in_fire && in_data.cmd == CMD_DISARM && armed_r) begin
        armed_r <= 1'b0;
        vld_r   <= '0;
      end
      if (state_r == S_SUM) vld_r[ax_r] <= 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
      ax_r <= '0;
      m_r  <= '0;
      if (in_data.cmd == CMD_DISARM) begin
        for (int m = 0; m < MOTOR_COUNT; m++) mot_r[m] <= idle_clamp;
      end
    end
    unique case (state_r)
      S_LOAD: begin
        integ_r <= st_ld.integ;
        e_r     <= e_c;
        d_r     <= d_c;
        quo_r   <= {1'b0, prod1};
        if (!en_r[ax_r]) begin
          rsh_r[ax_r] <= st_ld.rout;
          ax_r        <= ax_r + AX_W'(1);
        end
      end
      // Scale |e| * dt down by 500000
      S_ISCALE: quo_r <= {19'b0, iprod[63:INT_RECIP_SH]};
      S_DIV2: begin
        rem_r <= div_ge ? div_sub[DVSR_W-1:0] : div_sh[DVSR_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], div_ge};
        cnt_r <= cnt_r - CNT_W'(1);
      end
      S_INTEG: begin
        integ_r <= sat32(64'(isum));
        rem_r   <= '0;
        quo_r   <= (in_r.dt_us == '0) ? '0 : prod2;
        dvsr_r  <= in_r.dt_us;
        cnt_r   <= CNT_W'(DIV_W);
      end
      S_MUL: begin
        p1_r <= $signed(gain_sel[15:0]) * e_r;
        p2_r <= $signed(gain_sel[31:16]) * integ_r;
        p3_r <= $signed(gain_sel[47:32]) * $signed({1'b0, quo_r});
      end
      S_SUM: begin
        rsh_r[ax_r] <= rout_new;
        ax_r        <= ax_r + AX_W'(1);
      end
      S_MIXA: lvl_r <= $signed({1'b0, thr}) * wsum;
      S_MIXB: scl_r <= span * $signed({1'b0, lvlc});
      S_MIXC: begin
        mot_r[m_r] <= cmd_clamp;
        m_r        <= m_r + MOT_W'(1);
      end
      default: ;
    endcase
    if (out_load) begin
      out_r.motor_front_right <= mot_r[0];
      out_r.motor_front_left  <= mot_r[1];
      out_r.motor_back_left   <= mot_r[2];
      out_r.motor_back_right  <= mot_r[3];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: design/tpqm_ram.sv
`timescale 1ns / 1ps

module tpqm_ram #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [((D>1)?$clog2(D):1)-1:0] waddr,
  input  logic [W-1:0]                 wdata,
  input  logic [((D>1)?$clog2(D):1)-1:0] raddr,
  output logic [W-1:0]                 rdata
);

  logic [W-1:0] mem [D];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/tpqm_checker.sv
`timescale 1ns / 1ps

module tpqm_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input tpqm_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input tpqm_pkg::out_t out_data
);
  import tpqm_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Arm and unknown commands leave the block ready
  a_arm_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.cmd == CMD_ARM || in_data.cmd == CMD_RSVD)
    |=> in_ready)
    else $error("block busy after a command that does no work");

  // Arm never produces a result
  a_arm_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.cmd == CMD_ARM |=> !$rose(out_valid))
    else $error("result produced by arm");

endmodule

bind three_axis_pid_quad_motor_mixer_unit tpqm_checker u_tpqm_checker (.*);

FILE: tb/sv/three_axis_pid_quad_motor_mixer_unit_tb.sv
`timescale 1ns / 1ps

module three_axis_pid_quad_motor_mixer_unit_tb;
  import tpqm_pkg::*;

  // Regulator and mixer predictor with a queue of pending motor commands
  class motor_cmd_scoreboard;
    logic [47:0] gain [3];
    logic [2:0]  ena;
    logic [11:0] signs;
    logic [15:0] cmd_floor, cmd_ceil, cmd_idle;
    bit          armed;
    longint      integ [3];
    longint      prev  [3];
    longint      rout  [3];
    out_t        pending_cmds [$];
    int          n_err;

    function void clear_state();
      for (int a = 0; a < 3; a++) begin
        integ[a] = 0;
        prev[a] = 0;
        rout[a] = 0;
      end
    endfunction

    function void reset_all();
      for (int a = 0; a < 3; a++) gain[a] = GAIN_RST;
      ena = ENABLE_RST;
      signs = SIGNS_RST;
      cmd_floor = FLOOR_RST;
      cmd_ceil = CEILING_RST;
      cmd_idle = IDLE_RST;
      armed = 0;
      clear_state();
      n_err = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] v);
      case (idx)
        REG_GAIN0:   gain[0] = v;
        REG_GAIN1:   gain[1] = v;
        REG_GAIN2:   gain[2] = v;
        REG_ENABLE:  ena = v[2:0];
        REG_SIGNS:   signs = v[11:0];
        REG_FLOOR:   cmd_floor = v[15:0];
        REG_CEILING: cmd_ceil = v[15:0];
        REG_IDLE:    cmd_idle = v[15:0];
        default: ;
      endcase
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Arithmetic shift right rounds toward minus infinity
    function longint floor_div256(longint v);
      return v >>> 8;
    endfunction

    function logic [15:0] clamp_cmd(longint c);
      if (c < longint'(cmd_idle)) return cmd_idle;
      if (c > longint'(cmd_ceil)) return cmd_ceil;
      return c[15:0];
    endfunction

    function void regulate_axis(int a, longint meas, longint targ, longint dt);
      longint e, d, kp, ki, kd, deriv, sum;
      e = targ - meas;
      d = meas - prev[a];
      kp = longint'($signed(gain[a][15:0]));
      ki = longint'($signed(gain[a][31:16]));
      kd = longint'($signed(gain[a][47:32]));
      deriv = 0;
      integ[a] = sat32(integ[a] + (e * dt) / 500000);
      if (dt != 0) deriv = (d * 2000000) / dt;
      sum = 2 * kp * e + ki * integ[a] - kd * deriv;
      rout[a] = sat32(floor_div256(sum));
      prev[a] = meas;
    endfunction

    function void note_beat(in_t b);
      out_t   r;
      longint t, span, lvl, term, c;
      logic [15:0] m [4];
      longint meas [3], targ [3];
      meas[0] = longint'(b.measured_yaw);   targ[0] = longint'(b.target_yaw);
      meas[1] = longint'(b.measured_pitch); targ[1] = longint'(b.target_pitch);
      meas[2] = longint'(b.measured_roll);  targ[2] = longint'(b.target_roll);
      if (b.cmd == CMD_ARM) begin
        armed = 1;
        return;
      end
      if (b.cmd == CMD_DISARM) begin
        if (!armed) return;
        armed = 0;
        clear_state();
        r.motor_front_right = clamp_cmd(longint'(cmd_idle));
        r.motor_front_left  = clamp_cmd(longint'(cmd_idle));
        r.motor_back_left   = clamp_cmd(longint'(cmd_idle));
        r.motor_back_right  = clamp_cmd(longint'(cmd_idle));
        pending_cmds.push_back(r);
        return;
      end
      if (b.cmd != CMD_TICK || !armed) return;
      for (int a = 0; a < 3; a++)
        if (ena[a]) regulate_axis(a, meas[a], targ[a], longint'(b.dt_us));
      t = longint'(b.throttle_stick) + 32768;
      span = longint'(cmd_ceil) - longint'(cmd_floor);
      for (int k = 0; k < 4; k++) begin
        lvl = t * 65536;
        for (int a = 0; a < 3; a++) begin
          term = rout[a] * t;
          if (signs[3*k+a]) lvl -= term;
          else lvl += term;
        end
        if (lvl < 0) lvl = 0;
        if (lvl > 64'sd4294967296) lvl = 64'sd4294967296;
        c = longint'(cmd_floor) + ((span * lvl) >>> 32);
        m[k] = clamp_cmd(c);
      end
      r.motor_front_right = m[0];
      r.motor_front_left  = m[1];
      r.motor_back_left   = m[2];
      r.motor_back_right  = m[3];
      pending_cmds.push_back(r);
    endfunction

    function void check_beat(out_t got);
      out_t exp_cmd;
      if (pending_cmds.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected output beat %h", got);
        return;
      end
      exp_cmd = pending_cmds.pop_front();
      if (got.motor_front_right !== exp_cmd.motor_front_right ||
          got.motor_front_left  !== exp_cmd.motor_front_left  ||
          got.motor_back_left   !== exp_cmd.motor_back_left   ||
          got.motor_back_right  !== exp_cmd.motor_back_right) begin
        n_err++;
        if (n_err <= 10)
          $display("motor mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                   exp_cmd.motor_front_right, exp_cmd.motor_front_left,
                   exp_cmd.motor_back_left, exp_cmd.motor_back_right,
                   got.motor_front_right, got.motor_front_left,
                   got.motor_back_left, got.motor_back_right);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [47:0] cfg_wdata;

  motor_cmd_scoreboard sb;
  bit stall_long;
  bit drain_on;

  three_axis_pid_quad_motor_mixer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #8000000;
    $display("TEST FAILED");
    $finish;
  end

  // Drive one register write, then drop the enable
  task automatic write_cfg(logic [2:0] idx, logic [47:0] v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // Offer one input beat after a random gap, hold until accepted;
  // valid stays high into a back-to-back beat
  task automatic send_beat(in_t b, int max_gap);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(b);
    @(negedge clk);
  endtask

  // Drop valid, then wait for all pending commands plus the block's worst latency
  task automatic wait_idle();
    in_valid <= 0;
    while (sb.pending_cmds.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  function automatic in_t rand_beat(logic [1:0] c);
    in_t b;
    b.cmd = c;
    case ($urandom_range(0, 4))
      0: b.dt_us = 0;
      1: b.dt_us = 20'hFFFFF;
      2: b.dt_us = 20'($urandom);
      default: b.dt_us = 20'($urandom_range(100, 20000));
    endcase
    b.measured_yaw = 16'($urandom);   b.target_yaw = 16'($urandom);
    b.measured_pitch = 16'($urandom); b.target_pitch = 16'($urandom);
    b.measured_roll = 16'($urandom);  b.target_roll = 16'($urandom);
    b.throttle_stick = 16'($urandom);
    if ($urandom_range(0, 2) != 0) begin
      // Small errors keep motors inside the command band
      b.measured_yaw = $signed(b.target_yaw) + $signed(16'($urandom_range(0, 400)) - 16'd200);
      b.measured_pitch = $signed(b.target_pitch) + $signed(16'($urandom_range(0, 400)) - 16'd200);
      b.measured_roll = $signed(b.target_roll) + $signed(16'($urandom_range(0, 400)) - 16'd200);
    end
    return b;
  endfunction

  function automatic logic [47:0] rand_gain();
    logic [47:0] g;
    g = 48'({$urandom, $urandom});
    if ($urandom_range(0, 1)) begin
      // Modest gains in Q8.8
      g[15:0]  = 16'($urandom_range(0, 1024)) - 16'd256;
      g[31:16] = 16'($urandom_range(0, 512)) - 16'd128;
      g[47:32] = 16'($urandom_range(0, 64)) - 16'd16;
    end
    return g;
  endfunction

  // Receiver: random ready with a long hold-off when asked
  initial begin
    int gap;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (stall_long) begin
        out_ready <= 0;
        repeat (3000) @(negedge clk);
        stall_long = 0;
      end
      gap = drain_on ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
      sb.check_beat(out_data);
    end
  end

  initial begin
    in_t b;
    int  lo;
    sb = new();
    sb.reset_all();
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_idx = REG_GAIN0;
    cfg_wdata = '0;
    stall_long = 0;
    drain_on = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: tick while disarmed, disarm while disarmed, ignored code
    send_beat(rand_beat(CMD_TICK), 2);
    send_beat(rand_beat(CMD_DISARM), 2);
    send_beat(rand_beat(CMD_RSVD), 2);
    send_beat(rand_beat(CMD_ARM), 2);
    send_beat(rand_beat(CMD_ARM), 2);
    // Field extremes and zero dt
    b = rand_beat(CMD_TICK);
    b.dt_us = 0;
    send_beat(b, 2);
    b = '0; b.cmd = CMD_TICK; b.dt_us = 20'hFFFFF;
    b.measured_yaw = 16'sh8000; b.measured_pitch = 16'sh7FFF; b.measured_roll = 16'sh8000;
    b.target_yaw = 16'sh7FFF; b.target_pitch = 16'sh8000; b.target_roll = 16'sh7FFF;
    b.throttle_stick = 16'sh7FFF;
    send_beat(b, 2);
    b.throttle_stick = 16'sh8000; b.dt_us = 1;
    send_beat(b, 2);
    b = '1; b.cmd = CMD_TICK;
    send_beat(b, 2);
    send_beat(rand_beat(CMD_RSVD), 2);
    send_beat(rand_beat(CMD_DISARM), 2);
    wait_idle();

    // Extreme register settings: max, min and minus-one gains, all enabled, ceiling below floor, idle high
    write_cfg(REG_GAIN0, 48'h7FFF_7FFF_7FFF);
    write_cfg(REG_GAIN1, 48'h8000_8000_8000);
    write_cfg(REG_GAIN2, 48'hFFFF_FFFF_FFFF);
    write_cfg(REG_ENABLE, 48'd7);
    write_cfg(REG_SIGNS, 48'hFFF);
    write_cfg(REG_FLOOR, 48'd3000);
    write_cfg(REG_CEILING, 48'd1000);
    write_cfg(REG_IDLE, 48'd2500);
    send_beat(rand_beat(CMD_ARM), 2);
    for (int i = 0; i < 6; i++) send_beat(rand_beat(CMD_TICK), 2);
    send_beat(rand_beat(CMD_DISARM), 2);
    wait_idle();
    write_cfg(REG_GAIN0, '0);
    write_cfg(REG_ENABLE, 48'd0);
    write_cfg(REG_SIGNS, 48'h000);
    write_cfg(REG_FLOOR, 48'hFFFF);
    write_cfg(REG_CEILING, 48'hFFFF);
    write_cfg(REG_IDLE, 48'h0000);
    send_beat(rand_beat(CMD_ARM), 2);
    for (int i = 0; i < 3; i++) send_beat(rand_beat(CMD_TICK), 2);
    send_beat(rand_beat(CMD_DISARM), 2);
    wait_idle();

    // Random phases; each phase starts from fresh registers
    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(REG_GAIN0, rand_gain());
      write_cfg(REG_GAIN1, rand_gain());
      write_cfg(REG_GAIN2, rand_gain());
      write_cfg(REG_ENABLE,
                48'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 7));
      write_cfg(REG_SIGNS,
                48'(($urandom_range(0, 1)) ? 32'(SIGNS_RST) : $urandom_range(0, 4095)));
      lo = $urandom_range(800, 1200);
      if (ph == 7) begin
        write_cfg(REG_FLOOR, 48'($urandom));
        write_cfg(REG_CEILING, 48'($urandom));
        write_cfg(REG_IDLE, 48'($urandom));
      end else begin
        write_cfg(REG_FLOOR, 48'(lo));
        write_cfg(REG_CEILING, 48'(lo + $urandom_range(500, 1500)));
        write_cfg(REG_IDLE, 48'(lo - $urandom_range(0, 200)));
      end
      if (ph == 2) stall_long = 1;
      send_beat(rand_beat(CMD_ARM), 10);
      for (int i = 0; i < 105; i++) begin
        case ($urandom_range(0, 29))
          0:       send_beat(rand_beat(CMD_DISARM), 10);
          1:       send_beat(rand_beat(CMD_ARM), 10);
          2:       send_beat(rand_beat(CMD_RSVD), 10);
          default: send_beat(rand_beat(CMD_TICK), ($urandom_range(0, 3) == 0) ? 0 : 10);
        endcase
      end
      send_beat(rand_beat(CMD_DISARM), 10);
      wait_idle();
    end

    drain_on = 1;
    wait_idle();
    if (sb.n_err == 0 && sb.pending_cmds.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
